// File: rtl/tlc_pkg.sv
// Shared item types and register index codes for the two-level cache core.
package tlc_pkg;

    // One access: read or write to a byte address
    typedef struct packed {
        logic        cmd;
        logic [31:0] address;
    } t_in_item;

    // One access report
    typedef struct packed {
        logic        l1_hit;
        logic        l1_writeback;
        logic        l2_read;
        logic        l2_hit;
        logic        l2_evicted;
        logic        back_invalidated;
        logic        memory_read;
        logic        memory_write;
        logic [31:0] victim_address;
    } t_out_item;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_BLOCK_OFFSET_BITS = 3'd0;
    localparam logic [2:0] CFG_L1_INDEX_BITS     = 3'd1;
    localparam logic [2:0] CFG_L1_WAYS           = 3'd2;
    localparam logic [2:0] CFG_L2_INDEX_BITS     = 3'd3;
    localparam logic [2:0] CFG_L2_WAYS           = 3'd4;

endpackage

// File: rtl/two_level_inclusive_lru_cache_core.sv
// Top level of the two-level inclusive LRU write-back cache tag core.
// Tag-only model of a write-back, write-allocate L1 over an inclusive L2, both with true LRU.
// Each set of each level is one row of a synchronous RAM; one access is handled at a time by a
// read-modify-write sequencer, and an item is accepted only while the sequencer is idle. The
// report is offered after the L1 lookup on an L1 hit, and after the L2 lookup on an L1 miss;
// a dirty L1 victim adds an L2 writeback round trip (ST_WB, ST_RD2) before the L2 lookup and
// an L2 eviction adds an L1 back-invalidation round trip (ST_BI) after it. The next item can
// be accepted in the same cycle as the report is offered; a report still stalled at the
// output holds the next item in its last state. These steps follow from the dependent
// registered reads of the two set RAMs. After reset the block clears both RAMs, one row a
// cycle, max(L1_MAX_SETS, L2_MAX_SETS) rows (512 by default), before it takes its first
// item; configuration writes are accepted throughout.
module two_level_inclusive_lru_cache_core #(
    parameter int L1_MAX_SETS = 64,
    parameter int L1_MAX_WAYS = 8,
    parameter int L2_MAX_SETS = 512,
    parameter int L2_MAX_WAYS = 16,
    parameter int ADDR_BITS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tlc_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output tlc_pkg::t_out_item o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [4:0]         i_cfg_data,
    output logic               o_cfg_ready
);

    localparam int AW     = ADDR_BITS;
    localparam int L1_LIM = $clog2(L1_MAX_SETS + 1) - 1;
    localparam int L2_LIM = $clog2(L2_MAX_SETS + 1) - 1;
    localparam int LIM    = (L1_LIM > L2_LIM) ? L1_LIM : L2_LIM;
    localparam int VW     = AW + LIM;
    localparam int VAW    = VW + 8;
    localparam int S1W    = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
    localparam int S2W    = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
    localparam int AG1    = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
    localparam int AG2    = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
    localparam int CN1    = $clog2(L1_MAX_WAYS + 1);
    localparam int CN2    = $clog2(L2_MAX_WAYS + 1);
    localparam int EW1    = AW + AG1 + 2;
    localparam int EW2    = AW + AG2 + 2;
    localparam int RW1    = L1_MAX_WAYS * EW1;
    localparam int RW2    = L2_MAX_WAYS * EW2;
    localparam int DB1    = AW + AG1;
    localparam int DB2    = AW + AG2;
    localparam int VB1    = AW + AG1 + 1;
    localparam int VB2    = AW + AG2 + 1;
    localparam int CLR_N  = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
    localparam int CLW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_L1   = 3'd1;
    localparam logic [2:0] ST_WB   = 3'd2;
    localparam logic [2:0] ST_RD2  = 3'd3;
    localparam logic [2:0] ST_L2   = 3'd4;
    localparam logic [2:0] ST_BI   = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]         r_state, n_state;
    logic               r_clr_busy;
    logic [CLW-1:0]     r_clr;
    logic [2:0]         r_bob, r_l1ib;
    logic [3:0]         r_l1w, r_l2ib;
    logic [4:0]         r_l2w;
    logic               r_wr;
    logic [AW-1:0]      r_blk;
    logic [VW-1:0]      r_vb, n_vb;
    tlc_pkg::t_out_item r_res, n_res, r_out;
    logic               r_out_valid;

    logic [3:0]     b1, b2;
    logic [CN1-1:0] w1;
    logic [CN2-1:0] w2;
    logic [5:0]     l1w_ext, l2w_ext;
    logic [VW-1:0]  m1, m2;
    logic [AW-1:0]  in_blk;
    logic           accept, out_free;

    logic [RW1-1:0] q1, u1_row, wd1;
    logic [RW2-1:0] q2, u2_row, wd2;
    logic [S1W-1:0] wa1, ra1;
    logic [S2W-1:0] wa2, ra2;
    logic           we1, we2;
    logic [VW-1:0]  u1_key, u2_key;
    logic           u1_hit, u2_hit;
    logic [AG1-1:0] u1_hw, u1_pick;
    logic [AG2-1:0] u2_hw, u2_pick;
    logic [EW1-1:0] e1;
    logic [EW2-1:0] e2;
    logic [VW-1:0]  vb1, vb2;
    logic [VAW-1:0] va_wide;

    // effective geometry from the configuration registers
    always_comb begin
        b1 = ({1'b0, r_l1ib} > 4'(L1_LIM)) ? 4'(L1_LIM) : {1'b0, r_l1ib};
        b2 = (r_l2ib > 4'(L2_LIM)) ? 4'(L2_LIM) : r_l2ib;
        l1w_ext = 6'(r_l1w);
        l2w_ext = 6'(r_l2w);
        if (l1w_ext == 6'd0) begin
            w1 = CN1'(1);
        end else if (l1w_ext > 6'(L1_MAX_WAYS)) begin
            w1 = CN1'(L1_MAX_WAYS);
        end else begin
            w1 = CN1'(r_l1w);
        end
        if (l2w_ext == 6'd0) begin
            w2 = CN2'(1);
        end else if (l2w_ext > 6'(L2_MAX_WAYS)) begin
            w2 = CN2'(L2_MAX_WAYS);
        end else begin
            w2 = CN2'(r_l2w);
        end
        m1 = (VW'(1) << b1) - VW'(1);
        m2 = (VW'(1) << b2) - VW'(1);
    end

    assign in_blk   = AW'(i_in_data.address) >> r_bob;
    assign o_in_stall = !((r_state == ST_IDLE) && !r_clr_busy);
    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // lookup keys: own tag, or a victim block's tag in the other level
    assign u1_key = (r_state == ST_BI) ? (r_vb >> b1) : VW'(r_blk >> b1);
    assign u2_key = (r_state == ST_WB) ? (r_vb >> b2) : VW'(r_blk >> b2);

    // set RAMs
    tlc_ram #(.WIDTH(RW1), .DEPTH(L1_MAX_SETS), .ADR_W(S1W)) u_l1_ram (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (wa1),
        .i_wdata (wd1),
        .i_raddr (ra1),
        .o_rdata (q1)
    );

    tlc_ram #(.WIDTH(RW2), .DEPTH(L2_MAX_SETS), .ADR_W(S2W)) u_l2_ram (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (wa2),
        .i_wdata (wd2),
        .i_raddr (ra2),
        .o_rdata (q2)
    );

    // set lookup units
    tlc_set #(
        .WAYS(L1_MAX_WAYS), .AGE_W(AG1), .TAG_W(AW), .KEY_W(VW), .CNT_W(CN1), .WAY_W(AG1)
    ) u_l1_set (
        .i_row      (q1),
        .i_key      (u1_key),
        .i_ways     (w1),
        .o_hit      (u1_hit),
        .o_hit_way  (u1_hw),
        .o_pick_way (u1_pick),
        .o_row      (u1_row)
    );

    tlc_set #(
        .WAYS(L2_MAX_WAYS), .AGE_W(AG2), .TAG_W(AW), .KEY_W(VW), .CNT_W(CN2), .WAY_W(AG2)
    ) u_l2_set (
        .i_row      (q2),
        .i_key      (u2_key),
        .i_ways     (w2),
        .o_hit      (u2_hit),
        .o_hit_way  (u2_hw),
        .o_pick_way (u2_pick),
        .o_row      (u2_row)
    );

    // victim entries and their block addresses
    assign e1      = q1[u1_pick*EW1 +: EW1];
    assign e2      = q2[u2_pick*EW2 +: EW2];
    assign vb1     = (VW'(e1[AW-1:0]) << b1) | (VW'(r_blk) & m1);
    assign vb2     = (VW'(e2[AW-1:0]) << b2) | (VW'(r_blk) & m2);
    assign va_wide = VAW'(vb2) << r_bob;

    // sequencer and RAM port control
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_vb    = r_vb;
        we1     = 1'b0;
        wa1     = S1W'(VW'(r_blk) & m1);
        wd1     = u1_row;
        ra1     = S1W'(VW'(in_blk) & m1);
        we2     = 1'b0;
        wa2     = S2W'(VW'(r_blk) & m2);
        wd2     = u2_row;
        ra2     = S2W'(VW'(r_blk) & m2);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_state = ST_L1;
                end
            end
            ST_L1: begin
                we1 = 1'b1;
                if (u1_hit) begin
                    wd1[u1_hw*EW1+DB1] = u1_row[u1_hw*EW1+DB1] | r_wr;
                    n_res.l1_hit = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    wd1[u1_pick*EW1 +: EW1] = {1'b1, r_wr, {AG1{1'b0}}, r_blk >> b1};
                    n_res.l2_read = 1'b1;
                    if (e1[VB1] && e1[DB1]) begin
                        n_res.l1_writeback = 1'b1;
                        n_vb    = vb1;
                        ra2     = S2W'(vb1 & m2);
                        n_state = ST_WB;
                    end else begin
                        n_state = ST_L2;
                    end
                end
            end
            ST_WB: begin
                // dirty L1 victim marks its L2 copy, if present
                wa2 = S2W'(r_vb & m2);
                if (u2_hit) begin
                    we2 = 1'b1;
                    wd2[u2_hw*EW2+DB2] = 1'b1;
                end
                n_state = ST_RD2;
            end
            ST_RD2: begin
                n_state = ST_L2;
            end
            ST_L2: begin
                we2 = 1'b1;
                if (u2_hit) begin
                    n_res.l2_hit = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    wd2[u2_pick*EW2 +: EW2] = {1'b1, 1'b0, {AG2{1'b0}}, r_blk >> b2};
                    n_res.memory_read = 1'b1;
                    if (e2[VB2]) begin
                        n_res.l2_evicted     = 1'b1;
                        n_res.victim_address = 32'(AW'(va_wide));
                        n_res.memory_write   = e2[DB2];
                        n_vb    = vb2;
                        ra1     = S1W'(vb2 & m1);
                        n_state = ST_BI;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_BI: begin
                // drop the evicted block's L1 copy
                wa1 = S1W'(r_vb & m1);
                wd1 = q1;
                if (u1_hit) begin
                    we1 = 1'b1;
                    wd1[u1_hw*EW1+DB1 +: 2] = 2'b00;
                    n_res.back_invalidated = 1'b1;
                    if (q1[u1_hw*EW1+DB1]) begin
                        n_res.memory_write = 1'b1;
                    end
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // clearing pass after reset
        if (r_clr_busy) begin
            we1 = {1'b0, r_clr} < (CLW+1)'(L1_MAX_SETS);
            wa1 = S1W'(r_clr);
            wd1 = '0;
            we2 = {1'b0, r_clr} < (CLW+1)'(L2_MAX_SETS);
            wa2 = S2W'(r_clr);
            wd2 = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr       <= '0;
            r_bob       <= 3'd6;
            r_l1ib      <= 3'd6;
            r_l1w       <= 4'd8;
            r_l2ib      <= 4'd9;
            r_l2w       <= 5'd16;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                if (r_clr == CLW'(CLR_N - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr <= r_clr + CLW'(1);
                end
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tlc_pkg::CFG_BLOCK_OFFSET_BITS: r_bob  <= i_cfg_data[2:0];
                    tlc_pkg::CFG_L1_INDEX_BITS:     r_l1ib <= i_cfg_data[2:0];
                    tlc_pkg::CFG_L1_WAYS:           r_l1w  <= i_cfg_data[3:0];
                    tlc_pkg::CFG_L2_INDEX_BITS:     r_l2ib <= i_cfg_data[3:0];
                    tlc_pkg::CFG_L2_WAYS:           r_l2w  <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wr  <= (i_in_data.cmd == tlc_pkg::CMD_WRITE);
            r_blk <= in_blk;
        end
        r_res <= n_res;
        r_vb  <= n_vb;
        if ((r_state == ST_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

endmodule

// File: rtl/tlc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ADR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [ADR_W-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tlc_set.sv
// Set lookup: tag match, LRU victim choice and age update over one set row.
module tlc_set #(
    parameter int WAYS  = 8,
    parameter int AGE_W = 3,
    parameter int TAG_W = 32,
    parameter int KEY_W = 41,
    parameter int CNT_W = 4,
    parameter int WAY_W = 3
) (
    input  logic [WAYS*(TAG_W+AGE_W+2)-1:0] i_row,
    input  logic [KEY_W-1:0]                i_key,
    input  logic [CNT_W-1:0]                i_ways,
    output logic                            o_hit,
    output logic [WAY_W-1:0]                o_hit_way,
    output logic [WAY_W-1:0]                o_pick_way,
    output logic [WAYS*(TAG_W+AGE_W+2)-1:0] o_row
);

    localparam int EW = TAG_W + AGE_W + 2;
    localparam logic [AGE_W-1:0] CAP = AGE_W'(WAYS - 1);

    logic [TAG_W-1:0] tag [WAYS];
    logic [AGE_W-1:0] age [WAYS];
    logic [WAYS-1:0]  vld, inuse, match, free, best, bump;
    logic             any_free;
    logic [WAY_W-1:0] free_way, old_way, tgt;

    always_comb begin
        // unpack the row and compare tags
        for (int i = 0; i < WAYS; i++) begin
            tag[i]   = i_row[i*EW +: TAG_W];
            age[i]   = i_row[i*EW+TAG_W +: AGE_W];
            vld[i]   = i_row[i*EW+TAG_W+AGE_W+1];
            inuse[i] = CNT_W'(i) < i_ways;
            match[i] = inuse[i] && vld[i] && (KEY_W'(tag[i]) == i_key);
            free[i]  = inuse[i] && !vld[i];
        end

        // oldest way: strictly older than lower ways, not younger than higher ones
        for (int i = 0; i < WAYS; i++) begin
            best[i] = inuse[i];
            for (int j = 0; j < WAYS; j++) begin
                if (j < i && inuse[j]) begin
                    best[i] = best[i] && (age[i] > age[j]);
                end else if (j > i && inuse[j]) begin
                    best[i] = best[i] && (age[i] >= age[j]);
                end
            end
        end

        // lowest matching way hits
        o_hit     = |match;
        o_hit_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                o_hit_way = WAY_W'(i);
            end
        end

        // highest invalid way is filled first
        any_free = |free;
        free_way = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (free[i]) begin
                free_way = WAY_W'(i);
            end
        end
        old_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (best[i]) begin
                old_way = WAY_W'(i);
            end
        end
        o_pick_way = any_free ? free_way : old_way;
        tgt        = o_hit ? o_hit_way : o_pick_way;

        // make the target most recent, age the younger valid ways
        o_row = i_row;
        for (int i = 0; i < WAYS; i++) begin
            bump[i] = inuse[i] && (WAY_W'(i) != tgt) && vld[i]
                      && (!vld[tgt] || (age[i] < age[tgt])) && (age[i] < CAP);
            if (WAY_W'(i) == tgt) begin
                o_row[i*EW+TAG_W +: AGE_W] = '0;
            end else if (bump[i]) begin
                o_row[i*EW+TAG_W +: AGE_W] = age[i] + AGE_W'(1);
            end
        end
    end

endmodule

// File: tb/sv/two_level_inclusive_lru_cache_core_tb.sv
// Testbench for the two-level inclusive LRU cache core: random and directed accesses, scoreboarded.
`timescale 1ns / 1ps

module two_level_inclusive_lru_cache_core_tb;

    localparam int L1_SETS   = 64;
    localparam int L1_WAYS   = 8;
    localparam int L2_SETS   = 512;
    localparam int L2_WAYS   = 16;
    localparam int WDOG_MAX  = 4000;
    localparam int PHASE_LEN = 155;
    localparam int N_PHASES  = 10;

    // Tag-state mirror of both levels, predicts one access report per item
    class cache_scoreboard;
        longint unsigned l1_tag[], l2_tag[];
        bit l1_vld[], l1_drt[], l2_vld[], l2_drt[];
        int l1_lru[], l2_lru[];
        int unsigned offset_bits, l1_idx, l1_nways, l2_idx, l2_nways;
        tlc_pkg::t_out_item reports[$];
        int errors, n_checked, n_l1_hits, n_l2_evicts;

        function new();
            l1_tag = new[L1_SETS * L1_WAYS];
            l1_vld = new[L1_SETS * L1_WAYS];
            l1_drt = new[L1_SETS * L1_WAYS];
            l1_lru = new[L1_SETS * L1_WAYS];
            l2_tag = new[L2_SETS * L2_WAYS];
            l2_vld = new[L2_SETS * L2_WAYS];
            l2_drt = new[L2_SETS * L2_WAYS];
            l2_lru = new[L2_SETS * L2_WAYS];
            offset_bits = 6; l1_idx = 6; l1_nways = 8; l2_idx = 9; l2_nways = 16;
        endfunction

        function void write_reg(logic [2:0] idx, logic [4:0] val);
            case (idx)
                tlc_pkg::CFG_BLOCK_OFFSET_BITS: offset_bits = val[2:0];
                tlc_pkg::CFG_L1_INDEX_BITS:     l1_idx = val[2:0];
                tlc_pkg::CFG_L1_WAYS:           l1_nways = val[3:0];
                tlc_pkg::CFG_L2_INDEX_BITS:     l2_idx = val[3:0];
                tlc_pkg::CFG_L2_WAYS:           l2_nways = val;
                default: ;
            endcase
        endfunction

        function int unsigned sat_ways(int unsigned w, int unsigned mx);
            return (w == 0) ? 1 : ((w > mx) ? mx : w);
        endfunction

        function int lookup(ref longint unsigned tg[], ref bit vl[], input int base,
                            input int ways, input longint unsigned t);
            for (int i = 0; i < ways; i++)
                if (vl[base + i] && tg[base + i] == t) return i;
            return -1;
        endfunction

        // Highest free way first, else oldest (lowest way on a tie)
        function int victim_way(ref bit vl[], ref int ag[], input int base, input int ways);
            int best;
            best = 0;
            for (int i = ways - 1; i >= 0; i--)
                if (!vl[base + i]) return i;
            for (int i = 1; i < ways; i++)
                if (ag[base + i] > ag[base + best]) best = i;
            return best;
        endfunction

        // Make way w most recent; ages saturate at cap
        function void promote(ref bit vl[], ref int ag[], input int base, input int ways,
                              input int w, input int cap);
            for (int i = 0; i < ways; i++) begin
                if (i == w || !vl[base + i]) continue;
                if ((!vl[base + w] || ag[base + i] < ag[base + w]) && ag[base + i] < cap)
                    ag[base + i]++;
            end
            ag[base + w] = 0;
        endfunction

        function void note_input(tlc_pkg::t_in_item it);
            tlc_pkg::t_out_item r;
            int unsigned b1, b2, w1, w2;
            longint unsigned blk, m1, m2, tag1, tag2, vb;
            int base1, base2, vbase, h, w, g;
            r = '0;
            b1 = (l1_idx > 6) ? 6 : l1_idx;
            b2 = (l2_idx > 9) ? 9 : l2_idx;
            w1 = sat_ways(l1_nways, L1_WAYS);
            w2 = sat_ways(l2_nways, L2_WAYS);
            blk = longint'(it.address) >> offset_bits;
            m1 = (64'd1 << b1) - 1;
            m2 = (64'd1 << b2) - 1;
            base1 = int'(blk & m1) * L1_WAYS;
            base2 = int'(blk & m2) * L2_WAYS;
            tag1 = blk >> b1;
            tag2 = blk >> b2;
            h = lookup(l1_tag, l1_vld, base1, w1, tag1);
            if (h >= 0) begin
                promote(l1_vld, l1_lru, base1, w1, h, L1_WAYS - 1);
                if (it.cmd == tlc_pkg::CMD_WRITE) l1_drt[base1 + h] = 1;
                r.l1_hit = 1;
            end else begin
                w = victim_way(l1_vld, l1_lru, base1, w1);
                // dirty L1 victim goes back into L2 if present there
                if (l1_vld[base1 + w] && l1_drt[base1 + w]) begin
                    vb = (l1_tag[base1 + w] << b1) | (blk & m1);
                    vbase = int'(vb & m2) * L2_WAYS;
                    g = lookup(l2_tag, l2_vld, vbase, w2, vb >> b2);
                    r.l1_writeback = 1;
                    if (g >= 0) begin
                        l2_drt[vbase + g] = 1;
                        promote(l2_vld, l2_lru, vbase, w2, g, L2_WAYS - 1);
                    end
                end
                promote(l1_vld, l1_lru, base1, w1, w, L1_WAYS - 1);
                l1_tag[base1 + w] = tag1;
                l1_vld[base1 + w] = 1;
                l1_drt[base1 + w] = (it.cmd == tlc_pkg::CMD_WRITE);
                r.l2_read = 1;
                h = lookup(l2_tag, l2_vld, base2, w2, tag2);
                if (h >= 0) begin
                    promote(l2_vld, l2_lru, base2, w2, h, L2_WAYS - 1);
                    r.l2_hit = 1;
                end else begin
                    r.memory_read = 1;
                    w = victim_way(l2_vld, l2_lru, base2, w2);
                    // L2 eviction, with back-invalidation of the L1 copy
                    if (l2_vld[base2 + w]) begin
                        vb = (l2_tag[base2 + w] << b2) | (blk & m2);
                        vbase = int'(vb & m1) * L1_WAYS;
                        g = lookup(l1_tag, l1_vld, vbase, w1, vb >> b1);
                        r.l2_evicted = 1;
                        r.victim_address = 32'((vb << offset_bits) & 64'hFFFF_FFFF);
                        if (l2_drt[base2 + w]) r.memory_write = 1;
                        if (g >= 0) begin
                            r.back_invalidated = 1;
                            if (l1_drt[vbase + g]) r.memory_write = 1;
                            l1_vld[vbase + g] = 0;
                            l1_drt[vbase + g] = 0;
                        end
                    end
                    promote(l2_vld, l2_lru, base2, w2, w, L2_WAYS - 1);
                    l2_tag[base2 + w] = tag2;
                    l2_vld[base2 + w] = 1;
                    l2_drt[base2 + w] = 0;
                end
            end
            reports.insert(reports.size(), r);
        endfunction

        function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_report(tlc_pkg::t_out_item a);
            tlc_pkg::t_out_item e;
            if (reports.size() == 0) begin
                $error("report with no access outstanding");
                errors++;
                return;
            end
            e = reports.pop_front();
            n_checked++;
            if (e.l1_hit) n_l1_hits++;
            if (e.l2_evicted) n_l2_evicts++;
            cmp("l1_hit", e.l1_hit, a.l1_hit);
            cmp("l1_writeback", e.l1_writeback, a.l1_writeback);
            cmp("l2_read", e.l2_read, a.l2_read);
            cmp("l2_hit", e.l2_hit, a.l2_hit);
            cmp("l2_evicted", e.l2_evicted, a.l2_evicted);
            cmp("back_invalidated", e.back_invalidated, a.back_invalidated);
            cmp("memory_read", e.memory_read, a.memory_read);
            cmp("memory_write", e.memory_write, a.memory_write);
            cmp("victim_address", e.victim_address, a.victim_address);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    tlc_pkg::t_in_item  i_in_data;
    logic               o_in_stall;
    logic               o_out_valid;
    tlc_pkg::t_out_item o_out_data;
    logic               i_out_stall;
    logic               i_cfg_valid;
    logic [2:0]         i_cfg_index;
    logic [4:0]         i_cfg_data;
    logic               o_cfg_ready;

    cache_scoreboard sb;
    bit quiet;
    int stall_left;
    int idle_cycles;

    two_level_inclusive_lru_cache_core DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Accepted items and reports, plus the no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_report(o_out_data);
            if (i_in_valid && !o_in_stall) sb.note_input(i_in_data);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WDOG_MAX) begin
                $display("FAILURE");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver back-pressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 4);
        end
    end

    task automatic send_access(logic cmd, logic [31:0] addr);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= '{cmd: cmd, address: addr};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [4:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Lower the valid, let every report arrive, then allow the longest latency
    task automatic drain();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Mostly blocks that collide in at most two L1 and L2 sets (some with high tags in set 0), the rest fully random
    function automatic logic [31:0] pick_address();
        int unsigned sel;
        logic [31:0] low;
        sel = $urandom_range(0, 9);
        low = $urandom & ((32'd1 << sb.offset_bits) - 1);
        if (sel < 6)
            return (32'($urandom_range(0, 23)) << 17)
                 | (32'($urandom_range(0, 1)) << sb.offset_bits) | low;
        else if (sel < 7)
            return (32'($urandom_range(0, 23)) << 26) | low;
        return $urandom;
    endfunction

    initial begin
        logic [4:0] cfg [5];
        sb = new();
        quiet = 0;
        stall_left = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = tlc_pkg::CFG_BLOCK_OFFSET_BITS;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: hit, write then read, one set overfilled at both levels, extreme addresses
        send_access(tlc_pkg::CMD_READ, 32'h0000_0000);
        send_access(tlc_pkg::CMD_WRITE, 32'h0000_0004);
        send_access(tlc_pkg::CMD_READ, 32'hFFFF_FFFF);
        send_access(tlc_pkg::CMD_WRITE, 32'hFFFF_FFC0);
        for (int k = 1; k <= 17; k++) send_access(tlc_pkg::CMD_WRITE, 32'(k) << 15);
        send_access(tlc_pkg::CMD_READ, 32'h0000_0000);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: cfg = '{5'd0, 5'd0, 5'd1, 5'd0, 5'd1};
                1: cfg = '{5'd7, 5'd7, 5'd15, 5'd15, 5'd31};
                2: cfg = '{5'd2, 5'd1, 5'd2, 5'd2, 5'd4};
                3: cfg = '{5'd4, 5'd3, 5'd0, 5'd5, 5'd0};
                4: cfg = '{5'd6, 5'd6, 5'd8, 5'd9, 5'd16};
                default: cfg = '{5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)),
                                 5'($urandom_range(0, 15)), 5'($urandom_range(0, 15)),
                                 5'($urandom_range(0, 31))};
            endcase
            write_cfg(tlc_pkg::CFG_BLOCK_OFFSET_BITS, cfg[0]);
            write_cfg(tlc_pkg::CFG_L1_INDEX_BITS, cfg[1]);
            write_cfg(tlc_pkg::CFG_L1_WAYS, cfg[2]);
            write_cfg(tlc_pkg::CFG_L2_INDEX_BITS, cfg[3]);
            write_cfg(tlc_pkg::CFG_L2_WAYS, cfg[4]);
            quiet = (ph == N_PHASES - 1);
            for (int n = 0; n < PHASE_LEN; n++)
                send_access(logic'($urandom_range(0, 1)), pick_address());
            drain();
        end

        $display("Checked %0d access reports over %0d cache geometries", sb.n_checked,
                 N_PHASES + 1);
        $display("L1 hits %0d, L2 evictions %0d", sb.n_l1_hits, sb.n_l2_evicts);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: two_level_inclusive_lru_cache_core.f
rtl/tlc_pkg.sv
rtl/tlc_ram.sv
rtl/tlc_set.sv
rtl/two_level_inclusive_lru_cache_core.sv
tb/sv/two_level_inclusive_lru_cache_core_tb.sv
